// ===== design/rtp_h264_depacketizer_unit_assert.svh =====
// Assertion macros shared by the depacketizer modules.
// Each macro expects clk and rst_n to exist in the including module.
`ifndef RTP_H264_DEPACKETIZER_UNIT_ASSERT_SVH
`define RTP_H264_DEPACKETIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RHD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RHD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rhd_pkg.sv =====
// Types, codes and helpers of the RTP H.264 depacketizer.
// No dependencies; used by rhd_seen_map, rhd_parser, rhd_out_queue and the top module.
package rhd_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int RUN_DEPTH  = 6;
  localparam int RUN_CNT_W  = $clog2(RUN_DEPTH + 1);
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [6:0]  PT_RESET    = 7'd96;
  localparam logic [15:0] LIMIT_RESET = 16'd1000;
  localparam logic [4:0]  NAL_SPS     = 5'd7;
  localparam logic [4:0]  NAL_STAP_A  = 5'd24;
  localparam logic [4:0]  NAL_FU_A    = 5'd28;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PAYLOAD_TYPE = 1'b0,
    CFG_DUP_LIMIT    = 1'b1
  } rhd_cfg_idx_t;

  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_HDR      = 14'b00000000000010,
    PH_CSRC     = 14'b00000000000100,
    PH_EXTH     = 14'b00000000001000,
    PH_EXTS     = 14'b00000000010000,
    PH_PHDR     = 14'b00000000100000,
    PH_SINGLE   = 14'b00000001000000,
    PH_STAPHI   = 14'b00000010000000,
    PH_STAPLO   = 14'b00000100000000,
    PH_STAPHDR  = 14'b00001000000000,
    PH_STAPBODY = 14'b00010000000000,
    PH_FUHDR    = 14'b00100000000000,
    PH_FUBODY   = 14'b01000000000000,
    PH_DROP     = 14'b10000000000000
  } rhd_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       abrt;
  } rhd_res_t;

  typedef struct packed {
    rhd_res_t [RUN_DEPTH-1:0] ent;
    logic [RUN_CNT_W-1:0]     cnt;
  } rhd_run_t;

  typedef struct packed {
    logic       rd_en;
    logic       chk_en;
    logic [7:0] row;
    logic [7:0] bit_idx;
  } rhd_seen_req_t;

  // Append one result to a run.
  function automatic rhd_run_t rhd_push(rhd_run_t r, logic [7:0] d, logic f, logic l,
                                        logic a);
    rhd_run_t o;
    o = r;
    if (r.cnt < RUN_CNT_W'(RUN_DEPTH)) begin
      o.ent[r.cnt].data  = d;
      o.ent[r.cnt].first = f;
      o.ent[r.cnt].last  = l;
      o.ent[r.cnt].abrt  = a;
      o.cnt = r.cnt + RUN_CNT_W'(1);
    end
    return o;
  endfunction

  // Append a start code and the NAL header byte.
  function automatic rhd_run_t rhd_start(rhd_run_t r, logic [7:0] hdr, logic l);
    rhd_run_t o;
    o = rhd_push(r, 8'h00, 1'b1, 1'b0, 1'b0);
    o = rhd_push(o, 8'h00, 1'b0, 1'b0, 1'b0);
    o = rhd_push(o, 8'h00, 1'b0, 1'b0, 1'b0);
    o = rhd_push(o, 8'h01, 1'b0, 1'b0, 1'b0);
    o = rhd_push(o, hdr, 1'b0, l, 1'b0);
    return o;
  endfunction

endpackage

// ===== design/rhd_in_if.sv =====
// Input channel: one RTP packet byte per beat with packet framing marks.
// Depends on nothing.
interface rhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, in_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, first_byte, last_byte, output ready);
endinterface

// ===== design/rhd_out_if.sv =====
// Result channel: one Annex-B stream byte or abort marker per beat.
// Depends on nothing.
interface rhd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       nal_first;
  logic       nal_last;
  logic       abort_nal;
  logic       run_last;

  modport source (output valid, out_byte, nal_first, nal_last, abort_nal, run_last,
                  input ready);
  modport sink   (input valid, out_byte, nal_first, nal_last, abort_nal, run_last,
                  output ready);
endinterface

// ===== design/rhd_seen_map.sv =====
// Set of seen RTP sequence numbers: 256 rows of 256 bits with row valid flags.
// Depends on rhd_pkg and the assertion header.
`include "rtp_h264_depacketizer_unit_assert.svh"
module rhd_seen_map (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rhd_pkg::rhd_seen_req_t req,
  input  logic [15:0]           dup_limit,
  output logic                  hit
);
  import rhd_pkg::*;

  logic [255:0] mem [256];
  logic [255:0] row_vld_r;
  logic [255:0] row_q_r;
  logic         row_q_vld_r;
  logic [7:0]   row_sel_r;
  logic [16:0]  cnt_r;
  logic [16:0]  cnt_inc;
  logic         upd;
  logic         clr;
  logic [255:0] wr_row;

  // Look up the bit of the checked sequence number
  assign hit     = row_q_vld_r & row_q_r[req.bit_idx];
  assign upd     = req.chk_en & ~hit;
  assign cnt_inc = cnt_r + 17'd1;
  assign clr     = upd & (cnt_inc > {1'b0, dup_limit});
  assign wr_row  = (row_q_vld_r ? row_q_r : '0) | (256'd1 << req.bit_idx);

  // Row read on the high sequence byte, write back on the check
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      row_q_r   <= mem[req.row];
      row_sel_r <= req.row;
    end
    if (upd && !clr) begin
      mem[row_sel_r] <= wr_row;
    end
  end

  // Row valid flags and fill count; clear the whole set past the limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      row_q_vld_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (req.rd_en) begin
        row_q_vld_r <= row_vld_r[req.row];
      end
      if (clr) begin
        row_vld_r <= '0;
        cnt_r     <= '0;
      end else if (upd) begin
        row_vld_r[row_sel_r] <= 1'b1;
        cnt_r                <= cnt_inc;
      end
    end
  end

  `RHD_ASSERT_NXT(a_seen_clear, clr, (row_vld_r == '0) && (cnt_r == '0), "seen set not cleared")

endmodule

// ===== design/rhd_parser.sv =====
// Input stage and packet parser: header, CSRC/extension skip, NAL framing.
// Depends on rhd_pkg, rhd_in_if and the assertion header.
`include "rtp_h264_depacketizer_unit_assert.svh"
module rhd_parser #(
  parameter int MAX_PACKET_BYTES = rhd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rhd_in_if.sink                 in_ch,
  input  logic [6:0]             payload_type,
  input  logic                   run_free,
  input  logic                   seen_hit,
  output rhd_pkg::rhd_seen_req_t seen_req,
  output logic                   ld,
  output rhd_pkg::rhd_run_t      run
);
  import rhd_pkg::*;

  localparam int BIDX_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [BIDX_W:0] MAX_B = (BIDX_W + 1)'(MAX_PACKET_BYTES);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             fb_r;
  logic             lb_r;
  logic             fire;

  rhd_phase_t       phase_r, phase_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [3:0]       csrc_r, csrc_nxt;
  logic             ext_r, ext_nxt;
  logic [17:0]      skip_r, skip_nxt;
  logic [7:0]       seqh_r, seqh_nxt;
  logic [2:0]       nri_r, nri_nxt;
  logic [15:0]      unit_r, unit_nxt;
  logic             fu_open_r, fu_open_nxt;
  logic             fu_end_r, fu_end_nxt;
  logic             sps_r, sps_nxt;
  logic             drop_r, drop_nxt;
  logic             rd_en_c, chk_en_c;

  // Input register: take a beat when empty or when the held beat moves on
  assign fire        = in_vld_r & run_free;
  assign in_ch.ready = ~in_vld_r | run_free;
  assign ld          = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
      fb_r      <= in_ch.first_byte;
      lb_r      <= in_ch.last_byte;
    end
  end

  assign seen_req.rd_en   = rd_en_c;
  assign seen_req.chk_en  = chk_en_c;
  assign seen_req.row     = in_byte_r;
  assign seen_req.bit_idx = in_byte_r;

  // Parse one byte and build its run of results
  always_comb begin
    logic        act;
    logic        last;
    logic        clos;
    logic        done;
    logic [4:0]  typ;
    logic [15:0] len;
    rhd_run_t    r;
    phase_nxt   = phase_r;
    bidx_nxt    = bidx_r;
    csrc_nxt    = csrc_r;
    ext_nxt     = ext_r;
    skip_nxt    = skip_r;
    seqh_nxt    = seqh_r;
    nri_nxt     = nri_r;
    unit_nxt    = unit_r;
    fu_open_nxt = fu_open_r;
    fu_end_nxt  = fu_end_r;
    sps_nxt     = sps_r;
    drop_nxt    = drop_r;
    rd_en_c     = 1'b0;
    chk_en_c    = 1'b0;
    r           = '0;
    act         = 1'b1;
    clos        = 1'b0;
    done        = 1'b0;
    typ         = in_byte_r[4:0];
    len         = {seqh_r, in_byte_r};

    // Packet start: cut any open packet
    if (fb_r) begin
      if (phase_nxt != PH_IDLE) begin
        if (fu_open_nxt || (((phase_nxt == PH_SINGLE) || (phase_nxt == PH_STAPBODY))
                            && sps_nxt)) begin
          r = rhd_push(r, 8'h00, 1'b0, 1'b0, 1'b1);
        end
        fu_open_nxt = 1'b0;
        fu_end_nxt  = 1'b0;
      end
      phase_nxt = PH_HDR;
      bidx_nxt  = '0;
      drop_nxt  = 1'b0;
      csrc_nxt  = '0;
      ext_nxt   = 1'b0;
      skip_nxt  = '0;
    end else if (phase_nxt == PH_IDLE) begin
      act = 1'b0;
    end

    last = lb_r || (({1'b0, bidx_nxt} + (BIDX_W + 1)'(1)) >= MAX_B);

    if (act) begin
      unique case (phase_nxt)
        PH_HDR: begin
          if (bidx_nxt == BIDX_W'(0)) begin
            csrc_nxt = in_byte_r[3:0];
            ext_nxt  = in_byte_r[4];
          end else if (bidx_nxt == BIDX_W'(1)) begin
            drop_nxt = in_byte_r[6:0] != payload_type;
          end else if (bidx_nxt == BIDX_W'(2)) begin
            seqh_nxt = in_byte_r;
            rd_en_c  = fire;
          end else if (bidx_nxt == BIDX_W'(3)) begin
            chk_en_c = fire;
            if (seen_hit || drop_nxt) begin
              phase_nxt = PH_DROP;
            end
          end else if (bidx_nxt == BIDX_W'(11)) begin
            if (csrc_nxt != 4'd0) begin
              phase_nxt = PH_CSRC;
              skip_nxt  = {12'd0, csrc_nxt, 2'b00};
            end else if (ext_nxt) begin
              phase_nxt = PH_EXTH;
              skip_nxt  = 18'd4;
            end else begin
              phase_nxt = PH_PHDR;
            end
          end
        end
        PH_CSRC: begin
          skip_nxt = skip_nxt - 18'd1;
          if (skip_nxt == 18'd0) begin
            if (ext_nxt) begin
              phase_nxt = PH_EXTH;
              skip_nxt  = 18'd4;
            end else begin
              phase_nxt = PH_PHDR;
            end
          end
        end
        PH_EXTH: begin
          skip_nxt = skip_nxt - 18'd1;
          if (skip_nxt == 18'd1) begin
            seqh_nxt = in_byte_r;
          end else if (skip_nxt == 18'd0) begin
            if (len != 16'd0) begin
              phase_nxt = PH_EXTS;
              skip_nxt  = {len, 2'b00};
            end else begin
              phase_nxt = PH_PHDR;
            end
          end
        end
        PH_EXTS: begin
          skip_nxt = skip_nxt - 18'd1;
          if (skip_nxt == 18'd0) begin
            phase_nxt = PH_PHDR;
          end
        end
        PH_PHDR: begin
          nri_nxt = in_byte_r[7:5];
          if (typ == NAL_STAP_A) begin
            phase_nxt = PH_STAPHI;
          end else if (typ == NAL_FU_A) begin
            phase_nxt = PH_FUHDR;
          end else begin
            if (typ == NAL_SPS) begin
              sps_nxt = 1'b1;
            end
            if (sps_nxt) begin
              if (fu_open_nxt) begin
                r = rhd_push(r, 8'h00, 1'b0, 1'b0, 1'b1);
              end
              fu_open_nxt = 1'b0;
              fu_end_nxt  = 1'b0;
              r = rhd_start(r, in_byte_r, last);
            end
            phase_nxt = PH_SINGLE;
          end
        end
        PH_SINGLE: begin
          if (sps_nxt) begin
            r = rhd_push(r, in_byte_r, 1'b0, last, 1'b0);
          end
        end
        PH_STAPHI: begin
          unit_nxt  = {in_byte_r, 8'h00};
          phase_nxt = PH_STAPLO;
        end
        PH_STAPLO: begin
          unit_nxt  = {unit_nxt[15:8], in_byte_r};
          phase_nxt = (unit_nxt != 16'd0) ? PH_STAPHDR : PH_STAPHI;
        end
        PH_STAPHDR, PH_STAPBODY: begin
          if ((phase_nxt == PH_STAPHDR) && (typ == NAL_SPS)) begin
            sps_nxt = 1'b1;
          end
          unit_nxt = unit_nxt - 16'd1;
          done     = unit_nxt == 16'd0;
          if (sps_nxt) begin
            if (phase_nxt == PH_STAPHDR) begin
              if (fu_open_nxt) begin
                r = rhd_push(r, 8'h00, 1'b0, 1'b0, 1'b1);
              end
              fu_open_nxt = 1'b0;
              fu_end_nxt  = 1'b0;
              r = rhd_start(r, in_byte_r, done || last);
            end else begin
              r = rhd_push(r, in_byte_r, 1'b0, done || last, 1'b0);
            end
          end
          phase_nxt = done ? PH_STAPHI : PH_STAPBODY;
        end
        PH_FUHDR: begin
          if (typ == NAL_SPS) begin
            sps_nxt = 1'b1;
          end
          if (sps_nxt) begin
            if (in_byte_r[7]) begin
              clos = in_byte_r[6] && last;
              if (fu_open_nxt) begin
                r = rhd_push(r, 8'h00, 1'b0, 1'b0, 1'b1);
              end
              r = rhd_start(r, {nri_nxt, typ}, clos);
              fu_open_nxt = !clos;
              fu_end_nxt  = in_byte_r[6] && !clos;
            end else if (fu_open_nxt) begin
              fu_end_nxt = in_byte_r[6];
              if (in_byte_r[6] && last) begin
                r = rhd_push(r, 8'h00, 1'b0, 1'b0, 1'b1);
                fu_open_nxt = 1'b0;
                fu_end_nxt  = 1'b0;
              end
            end
          end
          phase_nxt = PH_FUBODY;
        end
        PH_FUBODY: begin
          if (fu_open_nxt) begin
            clos = last && fu_end_nxt;
            r = rhd_push(r, in_byte_r, 1'b0, clos, 1'b0);
            if (clos) begin
              fu_open_nxt = 1'b0;
              fu_end_nxt  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase

      // Close the packet or advance the byte count
      if (last) begin
        phase_nxt = lb_r ? PH_IDLE : PH_DROP;
      end else if ({1'b0, bidx_nxt} < MAX_B) begin
        bidx_nxt = bidx_nxt + BIDX_W'(1);
      end
    end
    run = r;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bidx_r    <= '0;
      csrc_r    <= '0;
      ext_r     <= 1'b0;
      skip_r    <= '0;
      seqh_r    <= '0;
      nri_r     <= '0;
      unit_r    <= '0;
      fu_open_r <= 1'b0;
      fu_end_r  <= 1'b0;
      sps_r     <= 1'b0;
      drop_r    <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      bidx_r    <= bidx_nxt;
      csrc_r    <= csrc_nxt;
      ext_r     <= ext_nxt;
      skip_r    <= skip_nxt;
      seqh_r    <= seqh_nxt;
      nri_r     <= nri_nxt;
      unit_r    <= unit_nxt;
      fu_open_r <= fu_open_nxt;
      fu_end_r  <= fu_end_nxt;
      sps_r     <= sps_nxt;
      drop_r    <= drop_nxt;
    end
  end

  `RHD_ASSERT_IMP(a_run_fits, fire, run.cnt <= RUN_CNT_W'(RUN_DEPTH), "run overflow")
  `RHD_ASSERT_NXT(a_in_hold, in_vld_r && !run_free, in_vld_r && $stable(in_byte_r), "input beat lost")

endmodule

// ===== design/rhd_out_queue.sv =====
// Result run register and serializer: drains up to six results per byte.
// Depends on rhd_pkg, rhd_out_if and the assertion header.
`include "rtp_h264_depacketizer_unit_assert.svh"
module rhd_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  rhd_pkg::rhd_run_t run,
  output logic              run_free,
  rhd_out_if.source         out_ch
);
  import rhd_pkg::*;

  rhd_res_t [RUN_DEPTH-1:0] ent_r;
  logic [RUN_CNT_W-1:0]     cnt_r;
  logic [RUN_CNT_W-1:0]     idx_r;
  logic                     at_end;
  logic                     beat;
  rhd_res_t                 cur;

  assign cur              = ent_r[idx_r];
  assign at_end           = idx_r == (cnt_r - RUN_CNT_W'(1));
  assign out_ch.valid     = idx_r != cnt_r;
  assign beat             = out_ch.valid & out_ch.ready;
  assign run_free         = ~out_ch.valid | (beat & at_end);
  assign out_ch.out_byte  = cur.data;
  assign out_ch.nal_first = cur.first;
  assign out_ch.nal_last  = cur.last;
  assign out_ch.abort_nal = cur.abrt;
  assign out_ch.run_last  = at_end;

  // Load a fresh run or advance through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (ld) begin
      cnt_r <= run.cnt;
      idx_r <= '0;
    end else if (beat) begin
      idx_r <= idx_r + RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ent_r <= run.ent;
    end
  end

  `RHD_ASSERT_NXT(a_run_shown, ld && (run.cnt != '0), out_ch.valid && (idx_r == '0), "run not presented")
  `RHD_ASSERT_IMP(a_abort_clean, out_ch.valid && out_ch.abort_nal, (out_ch.out_byte == 8'h00) && !out_ch.nal_first && !out_ch.nal_last, "abort beat carries data")

endmodule

// ===== design/rtp_h264_depacketizer_unit.sv =====
// RTP H.264 depacketizer (single NAL, STAP-A, FU-A) to an Annex-B byte stream.
// Channels: in_ch takes one RTP packet byte per beat, framed by first_byte
// and last_byte; out_ch gives one stream byte per beat (start codes 00 00 00 01
// ahead of each NAL), or an abort marker that cancels an unfinished NAL.
// run_last flags the final result caused by one input byte.
// cfg_we/cfg_addr/cfg_wdata write payload_type (index 0) and dup_limit
// (index 1); write them only while the block is idle.
// Path: an accepted byte waits in the input register; its run of results is
// then loaded into the run register, which drives out_ch. Throughput: one byte
// per cycle while each byte gives at most one result and out_ch is ready; a
// byte with more results keeps the run register until out_ch takes them all.
// A byte that starts a NAL gives up to six results and so stalls the input.
// Seen sequence numbers sit in a 256 x 256-bit memory with per-row valid
// flags, so reset and the clear past dup_limit take effect at once.
// Reset: synchronous, active low; drops everything in flight, forgets the SPS.
// A stalled receiver holds the current result; input stalls once the run
// register and the input register are both full.
module rtp_h264_depacketizer_unit #(
  parameter int MAX_PACKET_BYTES = rhd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rhd_in_if.sink                          in_ch,
  rhd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rhd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rhd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rhd_pkg::*;

  logic [6:0]    payload_type_r;
  logic [15:0]   dup_limit_r;
  logic          run_free;
  logic          ld;
  logic          seen_hit;
  rhd_run_t      run;
  rhd_seen_req_t seen_req;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_type_r <= PT_RESET;
      dup_limit_r    <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (rhd_cfg_idx_t'(cfg_addr))
        CFG_PAYLOAD_TYPE: payload_type_r <= cfg_wdata[6:0];
        CFG_DUP_LIMIT:    dup_limit_r    <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  rhd_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .payload_type (payload_type_r),
    .run_free     (run_free),
    .seen_hit     (seen_hit),
    .seen_req     (seen_req),
    .ld           (ld),
    .run          (run)
  );

  rhd_seen_map u_seen (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (seen_req),
    .dup_limit (dup_limit_r),
    .hit       (seen_hit)
  );

  rhd_out_queue u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .run      (run),
    .run_free (run_free),
    .out_ch   (out_ch)
  );

endmodule
